>>> rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define PTS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Invariant that must hold at every clock edge outside reset.
`define PTS_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    `PTS_ASSERT(label, clk, rstn, (expr), msg)

`endif

>>> rtl/pts_pkg.sv
// Shared types and constants of the priority task slot scheduler.
`default_nettype none

package pts_pkg;

    localparam int SLOT_IDX_W = 7;
    localparam int PRIO_W     = 4;
    localparam int PWR_W      = 2;
    localparam int OP_W       = 3;
    localparam int SID_W      = 4;
    localparam int RES_W      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_DELETE  = 3'd1,
        OP_SETPRIO = 3'd2,
        OP_PICK    = 3'd3,
        OP_QUERY   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CELL_NOP     = 2'd0,
        CELL_ALLOC   = 2'd1,
        CELL_FREE    = 2'd2,
        CELL_SETPRIO = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t              kind;
        logic [SLOT_IDX_W-1:0] idx;
        logic [PRIO_W-1:0]     prio;
        logic [PWR_W-1:0]      pwr;
        logic                  rep;
    } cell_cmd_t;

    typedef struct packed {
        logic                  found;
        logic [PRIO_W-1:0]     prio;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  rep;
    } cand_t;

endpackage

`default_nettype wire

>>> rtl/pts_cell.sv
// One task slot of the scheduler chain, holding the slot entry and one scan stage.
`default_nettype none

module pts_cell
    import pts_pkg::*;
#(
    parameter int CELL_INDEX      = 0,
    parameter int PRIORITY_LEVELS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_cmd_t         cmd,
    input  wire logic [PWR_W-1:0]  scan_pwr,
    input  wire cand_t             cand_in,
    output cand_t                  cand_out,
    output logic                   busy
);

    logic              busy_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [PWR_W-1:0]  pwr_reg;
    logic              rep_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              hit;
    logic              eligible;

    assign hit = (cmd.idx == SLOT_IDX_W'(CELL_INDEX));

    always_comb begin
        eligible = busy_reg && (pwr_reg == scan_pwr) &&
                   (32'(prio_reg) < PRIORITY_LEVELS);
        cand_next = cand_in;
        if (eligible && (!cand_in.found || prio_reg < cand_in.prio)) begin
            cand_next.found = 1'b1;
            cand_next.prio  = prio_reg;
            cand_next.idx   = SLOT_IDX_W'(CELL_INDEX);
            cand_next.rep   = rep_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            if (hit) begin
                unique case (cmd.kind)
                    CELL_ALLOC: begin
                        busy_reg <= 1'b1;
                    end
                    CELL_FREE: begin
                        busy_reg <= 1'b0;
                    end
                    CELL_SETPRIO,
                    CELL_NOP: begin
                        busy_reg <= busy_reg;
                    end
                    default: begin
                        busy_reg <= busy_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.found <= 1'b0;
        end else begin
            cand_reg.found <= cand_next.found;
        end
        cand_reg.prio <= cand_next.prio;
        cand_reg.idx  <= cand_next.idx;
        cand_reg.rep  <= cand_next.rep;
        if (hit && cmd.kind == CELL_ALLOC) begin
            prio_reg <= cmd.prio;
            pwr_reg  <= cmd.pwr;
            rep_reg  <= cmd.rep;
        end else if (hit && cmd.kind == CELL_SETPRIO) begin
            prio_reg <= cmd.prio;
        end
    end

    assign cand_out = cand_reg;
    assign busy     = busy_reg;

endmodule

`default_nettype wire

>>> rtl/priority_task_slot_scheduler.sv
// Top level of the priority task slot scheduler: control, free-slot stack and cell chain.
//
// One request beat enters on the s_ channel: s_tuser carries the operation (add, delete,
// change priority, pick, query) and s_tdata the slot, priority, power state and
// recurrent flag. Every request gives exactly one result beat on the m_ channel:
// m_tdata carries the slot number and m_tuser the error flag.
// Requests are handled one at a time. Add, delete, change priority and query pass
// from idle straight to the finish state, where the result is loaded once the output
// register is free. A pick first runs the candidate through the chain of SLOTS slot
// cells, one cell per cycle, in the scan state. The next request is taken in the cycle
// after a result is loaded, so no request is accepted while another is in progress.
// s_tready is high whenever no request is in progress, also while an earlier result
// still waits in the output register. If the receiver stalls, the finished request
// waits until the output register frees up, and no new request is taken meanwhile.
// Reset (aresetn low, synchronous) frees every slot, empties the table and restores
// the free-slot stack to slot 0 at the top, with no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module priority_task_slot_scheduler
    import pts_pkg::*;
#(
    parameter int SLOTS           = 16,
    parameter int PRIORITY_LEVELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // slot_id[3:0], priority_req[7:4], power_state[9:8], recurrent[10], zero[15:11]
    input  wire logic [15:0] s_tdata,
    // op[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_slot[3:0], zero[7:4]
    output logic [7:0]       m_tdata,
    // status[0]
    output logic [0:0]       m_tuser
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [SID_W-1:0]   sid_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [PWR_W-1:0]   pwr_reg;
    logic               rep_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   stack_rd_reg;
    logic [IDX_W-1:0]   stack_mem [SLOTS];
    logic [SLOTS-1:0]   stack_valid_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic [0:0]         m_tuser_reg;

    cand_t              cand_w [SLOTS+1];
    logic [SLOTS-1:0]   busy_vec;
    cell_cmd_t          cmd;
    logic               finish;
    logic               sid_valid;
    logic               sid_busy;
    logic               win_busy;
    logic               full;
    logic               ok;
    logic               release_en;
    logic [SLOT_IDX_W-1:0] release_idx;
    logic [SLOT_IDX_W-1:0] res_slot;

    assign cand_w[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pts_cell #(
            .CELL_INDEX      (g),
            .PRIORITY_LEVELS (PRIORITY_LEVELS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .scan_pwr (pwr_reg),
            .cand_in  (cand_w[g]),
            .cand_out (cand_w[g+1]),
            .busy     (busy_vec[g])
        );
    end

    assign full      = (count_reg == CNT_W'(SLOTS));
    assign sid_valid = (32'(sid_reg) < SLOTS);
    assign finish    = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        sid_busy = 1'b0;
        win_busy = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (sid_valid && 32'(sid_reg) == i) begin
                sid_busy = busy_vec[i];
            end
            if (32'(cand_w[SLOTS].idx) == i) begin
                win_busy = busy_vec[i];
            end
        end
    end

    always_comb begin
        ok          = 1'b0;
        res_slot    = '0;
        release_en  = 1'b0;
        release_idx = SLOT_IDX_W'(sid_reg);
        cmd.kind    = CELL_NOP;
        cmd.idx     = SLOT_IDX_W'(sid_reg);
        cmd.prio    = prio_reg;
        cmd.pwr     = pwr_reg;
        cmd.rep     = rep_reg;
        count_next  = count_reg;
        unique case (op_reg)
            OP_ADD: begin
                if (!full) begin
                    ok         = 1'b1;
                    res_slot   = SLOT_IDX_W'(stack_rd_reg);
                    cmd.kind   = CELL_ALLOC;
                    cmd.idx    = SLOT_IDX_W'(stack_rd_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (sid_busy) begin
                    ok         = 1'b1;
                    cmd.kind   = CELL_FREE;
                    release_en = 1'b1;
                end
            end
            OP_SETPRIO: begin
                if (sid_busy) begin
                    ok       = 1'b1;
                    cmd.kind = CELL_SETPRIO;
                end
            end
            OP_PICK: begin
                if (cand_w[SLOTS].found) begin
                    ok       = 1'b1;
                    res_slot = cand_w[SLOTS].idx;
                    if (!cand_w[SLOTS].rep) begin
                        cmd.kind    = CELL_FREE;
                        cmd.idx     = cand_w[SLOTS].idx;
                        release_en  = 1'b1;
                        release_idx = cand_w[SLOTS].idx;
                    end
                end
            end
            OP_QUERY: begin
                ok = sid_busy;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (release_en && count_reg != '0) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (!finish) begin
            cmd.kind   = CELL_NOP;
            count_next = count_reg;
        end
    end

    assign rd_addr = count_reg[IDX_W-1:0];
    assign wr_addr = count_next[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (32'(count_reg) < SLOTS) begin
            stack_rd_reg <= stack_valid_reg[rd_addr] ? stack_mem[rd_addr] : rd_addr;
        end else begin
            stack_rd_reg <= '0;
        end
        if (finish && release_en && count_reg != '0) begin
            stack_mem[wr_addr] <= release_idx[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= op_t'(s_tuser[2:0]);
            sid_reg  <= s_tdata[3:0];
            prio_reg <= s_tdata[7:4];
            pwr_reg  <= s_tdata[9:8];
            rep_reg  <= s_tdata[10];
        end
        if (finish) begin
            m_tdata_reg <= {4'b0000, res_slot[RES_W-1:0]};
            m_tuser_reg <= ok ? 1'b0 : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            scan_cnt_reg    <= '0;
            count_reg       <= '0;
            stack_valid_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (finish && release_en && count_reg != '0) begin
                stack_valid_reg[wr_addr] <= 1'b1;
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    scan_cnt_reg <= '0;
                    if (s_tvalid) begin
                        if (op_t'(s_tuser[2:0]) == OP_PICK) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    if (scan_cnt_reg == IDX_W'(SLOTS - 1)) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (finish) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PTS_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= CNT_W'(SLOTS), "Slot count exceeds the table size.")
    `PTS_ASSERT_ALWAYS(a_count_matches_busy, aclk, aresetn, $countones(busy_vec) == 32'(count_reg), "Slot count disagrees with the busy flags.")
    `PTS_ASSERT(a_winner_busy, aclk, aresetn, (state_reg == ST_FINISH && op_reg == OP_PICK && cand_w[SLOTS].found) |-> win_busy, "Pick winner is not a taken slot.")

endmodule

`default_nettype wire
